// ----- rtl/core/lbcq_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcq_pkg
// Shared types and constants of the linked-block character queue.
// ----------------------------------------------------------------------------
package lbcq_pkg;

   localparam int POOL_BLOCKS = 64;
   localparam int BLK_W       = 6;
   localparam int LINK_W      = 7;
   localparam int NUM_QUEUES  = 4;
   localparam int Q_W         = 2;
   localparam int CFG_W       = 7;
   localparam int AMT_W       = 12;
   localparam int CHAR_W      = 8;

   localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(POOL_BLOCKS);
   localparam logic [CFG_W-1:0]  POOL_RESET = 7'd50;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_UNPUT = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NO_BLOCK = 2'd2
   } status_type;

   typedef struct packed {
      logic              rd_en;
      logic [BLK_W-1:0]  rd_addr;
      logic              wr_en;
      logic [BLK_W-1:0]  wr_addr;
      logic [LINK_W-1:0] wr_data;
   } link_req_type;

   function automatic logic [CFG_W-1:0] sat_pool(input logic [CFG_W-1:0] v);
      sat_pool = (v > CFG_W'(POOL_BLOCKS)) ? CFG_W'(POOL_BLOCKS) : v;
   endfunction

endpackage

// ----- rtl/core/lbcq_ram.sv -----
// ----------------------------------------------------------------------------
// lbcq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lbcq_link.sv -----
// ----------------------------------------------------------------------------
// lbcq_link
// Block successor store. Entries not written since reset or a pool rebuild
// read as the initial free chain 0 -> 1 -> ... -> n-1.
// ----------------------------------------------------------------------------
module lbcq_link
   import lbcq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [CFG_W-1:0]  pool_n,
   input  link_req_type      req,
   output logic [LINK_W-1:0] rd_data
);

   logic [POOL_BLOCKS-1:0] vld_ff;
   logic                   rd_vld_ff;
   logic [BLK_W-1:0]       rd_addr_ff;
   logic [LINK_W-1:0]      ram_rd;
   logic [LINK_W-1:0]      succ;

   lbcq_ram #(.WIDTH(LINK_W), .DEPTH(POOL_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_en   (req.rd_en),
      .rd_addr (req.rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (req.wr_en) begin
         vld_ff[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
         rd_vld_ff  <= vld_ff[req.rd_addr];
         rd_addr_ff <= req.rd_addr;
      end
   end

   assign succ    = {1'b0, rd_addr_ff} + LINK_W'(1);
   assign rd_data = rd_vld_ff ? ram_rd : ((succ < pool_n) ? succ : NULL_LINK);

endmodule

// ----- rtl/core/linked_block_char_queue_core.sv -----
// ----------------------------------------------------------------------------
// linked_block_char_queue_core
// Four character queues built from linked blocks of a shared free pool.
//
// Requests (req_*) carry a command: put, get, unput or flush. Each request
// gives exactly one response (rsp_*) with the removed character, a status,
// the flush drop count and the free block count after the command.
// One request is in work at a time; req_stall is high while it runs and
// during a csr write.
// Put writes the character; when the queue takes its first block, or a
// full tail block is chained to a new one, it first takes the free head
// block (link read, then link write), and when chaining writes the link.
// Get and unput read the character; a get that ends its head block then
// reads that block's link. An unput that empties its tail block walks the
// chain from the head, releases the tail block and cuts. A queue that
// drains releases its block. Flush releases each block that it uses up
// mid-queue and the last when the queue drains. The steps follow from one
// link memory access per state and the registered reads of both memories.
// The response register holds a result while rsp_stall is high and the
// next request is accepted meanwhile; its result waits until the register
// frees. Reset, and a csr write while idle, empty all queues and rebuild the
// pool as the chain 0..n-1 with n = csr value (capped at 64); reset uses 50.
// ----------------------------------------------------------------------------
module linked_block_char_queue_core
   import lbcq_pkg::*;
#(
   parameter int BLOCK_CHARS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [Q_W-1:0]    req_queue_id,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              req_quote_in,
   input  logic [AMT_W-1:0]  req_flush_amount,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_char_out,
   output logic              rsp_quote_out,
   output logic [1:0]        rsp_status,
   output logic [AMT_W-1:0]  rsp_moved_count,
   output logic [CFG_W-1:0]  rsp_free_blocks,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   localparam int OW    = $clog2(BLOCK_CHARS);
   localparam int PW    = BLK_W + OW;
   localparam int DEPTH = POOL_BLOCKS * BLOCK_CHARS;
   localparam int CW    = PW + 1;
   localparam int MW    = (CW > AMT_W) ? CW : AMT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PUT_WR, S_TAKE_RD, S_TAKE_WR, S_CHAIN, S_CHAR_RD, S_CHAR_USE,
      S_NEXT_RD, S_NEXT_USE, S_GIVE, S_WALK_RD, S_WALK_USE, S_CUT, S_FLUSH,
      S_RESP
   } state_type;

   state_type          state_ff;
   logic [CFG_W-1:0]   pool_ff;
   logic [LINK_W-1:0]  free_head_ff;
   logic [CFG_W-1:0]   free_cnt_ff;
   logic [PW-1:0]      head_ff [NUM_QUEUES];
   logic [PW-1:0]      tail_ff [NUM_QUEUES];
   logic [CW-1:0]      cnt_ff  [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] has_ff;

   cmd_type            cmd_ff;
   logic [Q_W-1:0]     q_ff;
   logic [CHAR_W-1:0]  ch_ff;
   logic               qt_ff;
   logic [AMT_W-1:0]   amt_ff;
   logic [PW-1:0]      pos_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [BLK_W-1:0]   prev_ff;
   logic [LINK_W-1:0]  steps_ff;
   logic               cut_ff;

   logic [CHAR_W-1:0]  res_ch_ff;
   logic               res_qt_ff;
   status_type         res_st_ff;
   logic [AMT_W-1:0]   moved_ff;

   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_quote_ff;
   logic [1:0]         rsp_status_ff;
   logic [AMT_W-1:0]   rsp_moved_ff;
   logic [CFG_W-1:0]   rsp_free_ff;

   link_req_type       lreq;
   logic [LINK_W-1:0]  link_rd;
   logic               char_wr_en;
   logic               char_rd_en;
   logic [PW-1:0]      char_rd_addr;
   logic [CHAR_W:0]    char_rd;
   logic [CFG_W-1:0]   csr_n;
   logic [CFG_W-1:0]   rst_n_blocks;

   // flush step arithmetic
   logic [PW-1:0]      fl_pos;
   logic [OW:0]        fl_room;
   logic [MW-1:0]      fl_n_a;
   logic [MW-1:0]      fl_n;
   logic [CW-1:0]      fl_cnt_new;

   // unlink arithmetic for get and unput
   logic [CW-1:0]      rm_cnt_new;

   assign csr_n        = sat_pool(csr_wr_data);
   assign rst_n_blocks = sat_pool(POOL_RESET);

   assign fl_pos     = head_ff[q_ff];
   assign fl_room    = (OW+1)'(BLOCK_CHARS) - {1'b0, fl_pos[OW-1:0]};
   assign fl_n_a     = (MW'(amt_ff) < MW'(fl_room)) ? MW'(amt_ff) : MW'(fl_room);
   assign fl_n       = (MW'(cnt_ff[q_ff]) < fl_n_a) ? MW'(cnt_ff[q_ff]) : fl_n_a;
   assign fl_cnt_new = cnt_ff[q_ff] - CW'(fl_n);
   assign rm_cnt_new = cnt_ff[q_ff] - CW'(1);

   assign char_wr_en   = (state_ff == S_PUT_WR);
   assign char_rd_en   = (state_ff == S_CHAR_RD);
   assign char_rd_addr = (cmd_ff == CMD_GET) ? head_ff[q_ff] : tail_ff[q_ff];

   lbcq_ram #(.WIDTH(CHAR_W + 1), .DEPTH(DEPTH)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_wr_en),
      .wr_addr (tail_ff[q_ff]),
      .wr_data ({qt_ff, ch_ff}),
      .rd_en   (char_rd_en),
      .rd_addr (char_rd_addr),
      .rd_data (char_rd)
   );

   lbcq_link u_link (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_wr_en),
      .pool_n  (pool_ff),
      .req     (lreq),
      .rd_data (link_rd)
   );

   always_comb begin
      lreq = '0;
      unique case (state_ff)
         S_TAKE_RD: begin
            lreq.rd_en   = 1'b1;
            lreq.rd_addr = free_head_ff[BLK_W-1:0];
         end
         S_TAKE_WR: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = free_head_ff[BLK_W-1:0];
            lreq.wr_data = NULL_LINK;
         end
         S_CHAIN: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = tail_ff[q_ff][PW-1:OW];
            lreq.wr_data = {1'b0, blk_ff};
         end
         S_NEXT_RD: begin
            lreq.rd_en   = 1'b1;
            lreq.rd_addr = blk_ff;
         end
         S_GIVE: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = blk_ff;
            lreq.wr_data = free_head_ff;
         end
         S_WALK_RD: begin
            lreq.rd_en   = 1'b1;
            lreq.rd_addr = prev_ff;
         end
         S_CUT: begin
            lreq.wr_en   = 1'b1;
            lreq.wr_addr = prev_ff;
            lreq.wr_data = NULL_LINK;
         end
         default: begin
            lreq = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= rst_n_blocks;
         free_head_ff <= (rst_n_blocks != '0) ? '0 : NULL_LINK;
         free_cnt_ff  <= rst_n_blocks;
         has_ff       <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (csr_wr_en) begin
                  // rebuild pool and drop every queue
                  pool_ff      <= csr_n;
                  free_head_ff <= (csr_n != '0) ? '0 : NULL_LINK;
                  free_cnt_ff  <= csr_n;
                  has_ff       <= '0;
                  for (int i = 0; i < NUM_QUEUES; i++) begin
                     head_ff[i] <= '0;
                     tail_ff[i] <= '0;
                     cnt_ff[i]  <= '0;
                  end
               end else if (req_valid) begin
                  cmd_ff    <= cmd_type'(req_command);
                  q_ff      <= req_queue_id;
                  ch_ff     <= req_char_in;
                  qt_ff     <= req_quote_in;
                  amt_ff    <= req_flush_amount;
                  res_ch_ff <= '0;
                  res_qt_ff <= 1'b0;
                  res_st_ff <= ST_OK;
                  moved_ff  <= '0;
                  cut_ff    <= 1'b0;
                  steps_ff  <= '0;
                  unique case (cmd_type'(req_command))
                     CMD_PUT: begin
                        if (!has_ff[req_queue_id] ||
                            tail_ff[req_queue_id][OW-1:0] == {OW{1'b1}}) begin
                           if (free_head_ff[LINK_W-1]) begin
                              res_st_ff <= ST_NO_BLOCK;
                              state_ff  <= S_RESP;
                           end else begin
                              state_ff <= S_TAKE_RD;
                           end
                        end else begin
                           tail_ff[req_queue_id] <= tail_ff[req_queue_id] + PW'(1);
                           state_ff <= S_PUT_WR;
                        end
                     end
                     CMD_GET, CMD_UNPUT: begin
                        if (cnt_ff[req_queue_id] == '0) begin
                           res_st_ff <= ST_EMPTY;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_CHAR_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_FLUSH;
                     end
                  endcase
               end
            end
            S_PUT_WR: begin
               cnt_ff[q_ff] <= cnt_ff[q_ff] + CW'(1);
               state_ff     <= S_RESP;
            end
            S_TAKE_RD: begin
               state_ff <= S_TAKE_WR;
            end
            S_TAKE_WR: begin
               blk_ff       <= free_head_ff[BLK_W-1:0];
               free_head_ff <= link_rd;
               free_cnt_ff  <= free_cnt_ff - CFG_W'(1);
               if (!has_ff[q_ff]) begin
                  has_ff[q_ff]  <= 1'b1;
                  head_ff[q_ff] <= {free_head_ff[BLK_W-1:0], {OW{1'b0}}};
                  tail_ff[q_ff] <= {free_head_ff[BLK_W-1:0], {OW{1'b0}}};
                  cnt_ff[q_ff]  <= '0;
                  state_ff      <= S_PUT_WR;
               end else begin
                  state_ff <= S_CHAIN;
               end
            end
            S_CHAIN: begin
               tail_ff[q_ff] <= {blk_ff, {OW{1'b0}}};
               state_ff      <= S_PUT_WR;
            end
            S_CHAR_RD: begin
               pos_ff   <= char_rd_addr;
               blk_ff   <= char_rd_addr[PW-1:OW];
               state_ff <= S_CHAR_USE;
            end
            S_CHAR_USE: begin
               res_ch_ff    <= char_rd[CHAR_W-1:0];
               res_qt_ff    <= char_rd[CHAR_W];
               cnt_ff[q_ff] <= rm_cnt_new;
               if (rm_cnt_new == '0) begin
                  has_ff[q_ff]  <= 1'b0;
                  head_ff[q_ff] <= '0;
                  tail_ff[q_ff] <= '0;
                  state_ff      <= S_GIVE;
               end else if (cmd_ff == CMD_GET) begin
                  if (pos_ff[OW-1:0] == {OW{1'b1}}) begin
                     state_ff <= S_NEXT_RD;
                  end else begin
                     head_ff[q_ff] <= pos_ff + PW'(1);
                     state_ff      <= S_RESP;
                  end
               end else if (pos_ff[OW-1:0] == '0) begin
                  // tail block empties: find the block before it
                  prev_ff  <= head_ff[q_ff][PW-1:OW];
                  cut_ff   <= 1'b1;
                  state_ff <= S_WALK_RD;
               end else begin
                  tail_ff[q_ff] <= pos_ff - PW'(1);
                  state_ff      <= S_RESP;
               end
            end
            S_NEXT_RD: begin
               state_ff <= S_NEXT_USE;
            end
            S_NEXT_USE: begin
               head_ff[q_ff] <= link_rd[LINK_W-1] ? '0 :
                                {link_rd[BLK_W-1:0], {OW{1'b0}}};
               state_ff      <= S_GIVE;
            end
            S_GIVE: begin
               free_head_ff <= {1'b0, blk_ff};
               free_cnt_ff  <= free_cnt_ff + CFG_W'(1);
               if (cut_ff) begin
                  state_ff <= S_CUT;
               end else if (cmd_ff == CMD_FLUSH) begin
                  state_ff <= S_FLUSH;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_WALK_RD: begin
               state_ff <= S_WALK_USE;
            end
            S_WALK_USE: begin
               if (link_rd != {1'b0, blk_ff} && steps_ff < LINK_W'(POOL_BLOCKS) &&
                   !link_rd[LINK_W-1]) begin
                  prev_ff  <= link_rd[BLK_W-1:0];
                  steps_ff <= steps_ff + LINK_W'(1);
                  state_ff <= S_WALK_RD;
               end else begin
                  tail_ff[q_ff] <= {prev_ff, {OW{1'b1}}};
                  state_ff      <= S_GIVE;
               end
            end
            S_CUT: begin
               state_ff <= S_RESP;
            end
            S_FLUSH: begin
               if (amt_ff == '0 || cnt_ff[q_ff] == '0) begin
                  state_ff <= S_RESP;
               end else begin
                  amt_ff       <= amt_ff - AMT_W'(fl_n);
                  moved_ff     <= moved_ff + AMT_W'(fl_n);
                  cnt_ff[q_ff] <= fl_cnt_new;
                  blk_ff       <= fl_pos[PW-1:OW];
                  if (fl_cnt_new == '0) begin
                     has_ff[q_ff]  <= 1'b0;
                     head_ff[q_ff] <= '0;
                     tail_ff[q_ff] <= '0;
                     state_ff      <= S_GIVE;
                  end else if (fl_n == MW'(fl_room)) begin
                     state_ff <= S_NEXT_RD;
                  end else begin
                     head_ff[q_ff] <= fl_pos + PW'(fl_n);
                  end
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_char_ff   <= res_ch_ff;
                  rsp_quote_ff  <= res_qt_ff;
                  rsp_status_ff <= res_st_ff;
                  rsp_moved_ff  <= moved_ff;
                  rsp_free_ff   <= free_cnt_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE) || csr_wr_en;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_quote_out   = rsp_quote_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_free_blocks = rsp_free_ff;

endmodule

// ----- rtl/core/lbcq_checker.sv -----
// ----------------------------------------------------------------------------
// lbcq_checker
// Port-level checks of the linked-block character queue.
// ----------------------------------------------------------------------------
module lbcq_checker
   import lbcq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_char_out,
   input logic              rsp_quote_out,
   input logic [1:0]        rsp_status,
   input logic [AMT_W-1:0]  rsp_moved_count,
   input logic [CFG_W-1:0]  rsp_free_blocks
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out) &&
      $stable(rsp_status) && $stable(rsp_free_blocks))
      else $error("stalled response changed");

   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_BLOCK |-> rsp_free_blocks == '0)
      else $error("no-block status with free blocks left");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
      rsp_char_out == '0 && !rsp_quote_out && rsp_moved_count == '0)
      else $error("failed command returned data");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_blocks <= CFG_W'(POOL_BLOCKS))
      else $error("free count above pool size");

endmodule

bind linked_block_char_queue_core lbcq_checker u_lbcq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_char_out    (rsp_char_out),
   .rsp_quote_out   (rsp_quote_out),
   .rsp_status      (rsp_status),
   .rsp_moved_count (rsp_moved_count),
   .rsp_free_blocks (rsp_free_blocks)
);

// ----- verif/tb_linked_block_char_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_block_char_queue_core
// Drives put, get, unput and flush requests into the character queue core
// across several pool sizes and idle/stall mixes. A behavioral copy of the
// queues and free list predicts every response. Each response is checked
// field by field in order.
// ----------------------------------------------------------------------------
module tb_linked_block_char_queue_core;
   import lbcq_pkg::*;

   localparam int BLK_CHARS = 32;
   localparam int STORE_SZ  = POOL_BLOCKS * BLK_CHARS;
   localparam int NULL_BLK  = POOL_BLOCKS;

   typedef struct {
      logic [CHAR_W-1:0] char_out;
      logic              quote_out;
      status_type        status;
      logic [AMT_W-1:0]  moved;
      logic [CFG_W-1:0]  free_blocks;
   } char_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_command = CMD_GET;
   logic [Q_W-1:0]    req_queue_id = '0;
   logic [CHAR_W-1:0] req_char_in = '0;
   logic              req_quote_in = 1'b0;
   logic [AMT_W-1:0]  req_flush_amount = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CHAR_W-1:0] rsp_char_out;
   logic              rsp_quote_out;
   logic [1:0]        rsp_status;
   logic [AMT_W-1:0]  rsp_moved_count;
   logic [CFG_W-1:0]  rsp_free_blocks;
   logic              csr_wr_en = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   linked_block_char_queue_core #(.BLOCK_CHARS(BLK_CHARS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [7:0] char_mem [STORE_SZ];
   logic       quote_mem [STORE_SZ];
   int         blk_link [POOL_BLOCKS];
   int         free_head, free_cnt;
   int         head_pos [NUM_QUEUES];
   int         tail_pos [NUM_QUEUES];
   int         char_cnt [NUM_QUEUES];
   bit         owns_blk [NUM_QUEUES];

   char_rsp_type pending_rsp [$];
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         mismatches = 0;
   int         requests_sent = 0;
   int         rsp_checked = 0;
   int         no_block_seen = 0;

   function automatic void refill_pool(int n);
      if (n > POOL_BLOCKS) n = POOL_BLOCKS;
      for (int i = 0; i < POOL_BLOCKS; i++) blk_link[i] = (i + 1 < n) ? i + 1 : NULL_BLK;
      free_head = n ? 0 : NULL_BLK;
      free_cnt  = n;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_pos[i] = 0;
         tail_pos[i] = 0;
         char_cnt[i] = 0;
         owns_blk[i] = 0;
      end
   endfunction

   function automatic int take_blk();
      int b;
      b = free_head;
      if (b >= NULL_BLK) return NULL_BLK;
      free_head   = blk_link[b];
      blk_link[b] = NULL_BLK;
      free_cnt--;
      return b;
   endfunction

   function automatic void give_blk(int b);
      blk_link[b] = free_head;
      free_head   = b;
      free_cnt++;
   endfunction

   // drop the head block once it is used up or the queue drains
   function automatic void retire_head(int q, int b, int p);
      if (p % BLK_CHARS == 0 || char_cnt[q] == 0) begin
         if (char_cnt[q] > 0) begin
            head_pos[q] = blk_link[b] * BLK_CHARS;
         end else begin
            owns_blk[q] = 0;
            head_pos[q] = 0;
            tail_pos[q] = 0;
         end
         give_blk(b);
      end else begin
         head_pos[q] = p;
      end
   endfunction

   function automatic char_rsp_type apply_char_cmd(cmd_type cmd, int q, logic [7:0] ch,
                                                   logic qt, int amt);
      char_rsp_type r;
      int b, p, n, prev, steps;
      r = '{char_out: '0, quote_out: 1'b0, status: ST_OK, moved: '0, free_blocks: '0};
      case (cmd)
         CMD_PUT: begin
            b = 0;
            if (!owns_blk[q]) begin
               b = take_blk();
               if (b < NULL_BLK) begin
                  owns_blk[q] = 1;
                  head_pos[q] = b * BLK_CHARS;
                  tail_pos[q] = b * BLK_CHARS;
                  char_cnt[q] = 0;
               end
            end else if (tail_pos[q] % BLK_CHARS == BLK_CHARS - 1) begin
               b = take_blk();
               if (b < NULL_BLK) begin
                  blk_link[tail_pos[q] / BLK_CHARS] = b;
                  tail_pos[q] = b * BLK_CHARS;
               end
            end else begin
               tail_pos[q]++;
            end
            if (b < NULL_BLK) begin
               char_mem[tail_pos[q]]  = ch;
               quote_mem[tail_pos[q]] = qt;
               char_cnt[q]++;
            end else begin
               r.status = ST_NO_BLOCK;
            end
         end
         CMD_GET: begin
            if (char_cnt[q] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               p = head_pos[q];
               r.char_out  = char_mem[p];
               r.quote_out = quote_mem[p];
               char_cnt[q]--;
               retire_head(q, p / BLK_CHARS, p + 1);
            end
         end
         CMD_UNPUT: begin
            if (char_cnt[q] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               p = tail_pos[q];
               b = p / BLK_CHARS;
               r.char_out  = char_mem[p];
               r.quote_out = quote_mem[p];
               char_cnt[q]--;
               if (char_cnt[q] == 0) begin
                  give_blk(b);
                  owns_blk[q] = 0;
                  head_pos[q] = 0;
                  tail_pos[q] = 0;
               end else if (p % BLK_CHARS == 0) begin
                  // walk from the head block to find the one before the tail
                  prev  = head_pos[q] / BLK_CHARS;
                  steps = 0;
                  while (blk_link[prev] != b && steps < POOL_BLOCKS &&
                         blk_link[prev] < NULL_BLK) begin
                     prev = blk_link[prev];
                     steps++;
                  end
                  tail_pos[q] = prev * BLK_CHARS + BLK_CHARS - 1;
                  give_blk(b);
                  blk_link[prev] = NULL_BLK;
               end else begin
                  tail_pos[q] = p - 1;
               end
            end
         end
         default: begin
            while (amt > 0 && char_cnt[q] > 0) begin
               p = head_pos[q];
               n = BLK_CHARS - p % BLK_CHARS;
               if (n > amt) n = amt;
               if (n > char_cnt[q]) n = char_cnt[q];
               amt -= n;
               r.moved = r.moved + AMT_W'(n);
               char_cnt[q] -= n;
               retire_head(q, p / BLK_CHARS, p + n);
            end
         end
      endcase
      r.free_blocks = CFG_W'(free_cnt);
      return r;
   endfunction

   task automatic send_request(cmd_type cmd, int q, logic [7:0] ch, logic qt, int amt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_queue_id     <= Q_W'(q);
      req_char_in      <= ch;
      req_quote_in     <= qt;
      req_flush_amount <= AMT_W'(amt);
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_char_cmd(cmd, q, ch, qt, amt));
      requests_sent++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_pool(int n);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(n);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      refill_pool(n);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      char_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: response with no request outstanding");
         end else begin
            e = pending_rsp.pop_front();
            rsp_checked++;
            if (e.status == ST_NO_BLOCK) no_block_seen++;
            if (rsp_char_out !== e.char_out || rsp_quote_out !== e.quote_out ||
                rsp_status !== e.status || rsp_moved_count !== e.moved ||
                rsp_free_blocks !== e.free_blocks) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: rsp %0d exp ch=%h qt=%b st=%0d mv=%0d fb=%0d got ch=%h qt=%b st=%0d mv=%0d fb=%0d",
                           rsp_checked, e.char_out, e.quote_out, e.status, e.moved,
                           e.free_blocks, rsp_char_out, rsp_quote_out, rsp_status,
                           rsp_moved_count, rsp_free_blocks);
            end
         end
      end
   end

   task automatic test_empty_and_no_block();
      send_request(CMD_GET, 0, 8'h00, 1'b0, 0);
      send_request(CMD_UNPUT, 1, 8'h00, 1'b0, 0);
      send_request(CMD_FLUSH, 2, 8'h00, 1'b0, 2048);
      write_pool(0);
      send_request(CMD_PUT, 3, 8'hFF, 1'b1, 0);
      send_request(CMD_FLUSH, 3, 8'h00, 1'b0, 0);
   endtask

   task automatic test_directed_ops();
      write_pool(127);   // saturates to a full pool
      send_request(CMD_PUT, 0, 8'h00, 1'b0, 0);
      send_request(CMD_PUT, 0, 8'hFF, 1'b1, 0);
      send_request(CMD_PUT, 0, 8'hA5, 1'b1, 0);
      send_request(CMD_PUT, 0, 8'h5A, 1'b0, 0);
      send_request(CMD_GET, 0, 8'h00, 1'b0, 0);
      send_request(CMD_UNPUT, 0, 8'h00, 1'b0, 0);
      send_request(CMD_FLUSH, 0, 8'h00, 1'b0, 0);
      send_request(CMD_FLUSH, 0, 8'h00, 1'b0, 4095);
      send_request(CMD_GET, 0, 8'h00, 1'b0, 0);
      send_request(CMD_PUT, 2, 8'h7E, 1'b1, 0);
      send_request(CMD_UNPUT, 2, 8'h00, 1'b0, 0);
      write_pool(1);
      send_request(CMD_PUT, 1, 8'h11, 1'b0, 0);
      send_request(CMD_PUT, 2, 8'h22, 1'b1, 0);
      send_request(CMD_GET, 1, 8'h00, 1'b0, 0);
   endtask

   // puts most often, to build deep chains, with removals mixed in
   task automatic test_random_traffic(int pool_size, int count);
      int roll, amt;
      cmd_type cmd;
      write_pool(pool_size);
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         cmd  = roll < 45 ? CMD_PUT : roll < 70 ? CMD_GET : roll < 85 ? CMD_UNPUT : CMD_FLUSH;
         amt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
         send_request(cmd, $urandom_range(0, 3), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), amt);
      end
   endtask

   initial begin
      refill_pool(int'(POOL_RESET));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_no_block();
      test_directed_ops();
      test_random_traffic(64, 300);
      test_random_traffic(2, 150);
      send_idle_pct = 73;
      test_random_traffic(50, 350);
      rsp_stall_pct = 73;
      send_idle_pct = 0;
      test_random_traffic(3, 150);
      test_random_traffic(64, 300);
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      test_random_traffic($urandom_range(4, 63), 300);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(127, 280);
      drain_responses();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests over pool sizes 0..64 with idle and stall mixes;",
               requests_sent);
      $display("%0d responses checked, %0d no-block, %0d mismatches.",
               rsp_checked, no_block_seen, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("linked_block_char_queue_core test passed");
      end else begin
         $display("linked_block_char_queue_core test failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("linked_block_char_queue_core test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/lbcq_pkg.sv
rtl/core/lbcq_ram.sv
rtl/core/lbcq_link.sv
rtl/core/linked_block_char_queue_core.sv
rtl/core/lbcq_checker.sv
verif/tb_linked_block_char_queue_core.sv
